// File: hdl/multi_queue_shared_pool_top_assert.svh
// Assertion macros used by the checker file of the shared pool queue block.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef MULTI_QUEUE_SHARED_POOL_TOP_ASSERT_SVH
`define MULTI_QUEUE_SHARED_POOL_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MQSP_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MQSP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hdl/mqsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqsp_pkg
// Types and fixed constants of the multi-queue shared node pool: field widths,
// command and status codes, register map of the configuration port.
// ----------------------------------------------------------------------------
package mqsp_pkg;

    localparam int CMD_W    = 2;
    localparam int STAGE_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index taken from paddr[2]
    localparam logic [0:0] REG_STAGES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] STAGES_IN_USE_RESET = 4'd8;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_STAGE   = 2'd1,
        ST_NULL_HANDLE = 2'd2,
        ST_NO_NODE     = 2'd3
    } status_t;

endpackage
`default_nettype wire

// File: hdl/multi_queue_shared_pool_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted s_ beat is held in the input register, then executes into the result register.
// Throughput: one operation per cycle unless m_ready stalls the result; the single execute stage
// keeps head/link lookahead registers so the node memory read never stalls a back-to-back operation.
// Reset: aresetn is synchronous, active low; it empties all queues, the free list and the
// fresh-node counter at once and sets stages_in_use to 8. Node memories get no clearing pass.
// ----------------------------------------------------------------------------
// multi_queue_shared_pool_top
// Several FIFO queues sharing one pool of linked nodes that hold handles.
// Push, pop and count query, one result beat per command.
// ----------------------------------------------------------------------------
module multi_queue_shared_pool_top
    import mqsp_pkg::*;
#(
    parameter int MAX_STAGES   = 8,
    parameter int POOL_DEPTH   = 256,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [APB_ADDR_W-1:0]             paddr,
    input  wire logic [APB_DATA_W-1:0]             pwdata,
    output logic      [APB_DATA_W-1:0]             prdata,
    output logic                                   pready,
    // commands
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [CMD_W-1:0]                  s_cmd,
    input  wire logic [STAGE_W-1:0]                s_stage,
    input  wire logic [HANDLE_WIDTH-1:0]           s_handle_in,
    // results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [STATUS_W-1:0]               m_status,
    output logic      [HANDLE_WIDTH-1:0]           m_handle_out,
    output logic      [$clog2(POOL_DEPTH+1)-1:0]   m_count_out,
    output logic                                   m_became_nonempty,
    output logic                                   m_became_empty
);

    localparam int NODE_W = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int SIDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] stages_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stages_in_use_reg <= STAGES_IN_USE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_STAGES_IN_USE) begin
            stages_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_STAGES_IN_USE) begin
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, stages_in_use_reg};
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                    in_valid_reg;
    logic [CMD_W-1:0]        in_cmd_reg;
    logic [STAGE_W-1:0]      in_stage_reg;
    logic [HANDLE_WIDTH-1:0] in_hdl_reg;
    logic                    out_valid_reg;
    logic                    exec;

    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= s_cmd;
            in_stage_reg <= s_stage;
            in_hdl_reg   <= s_handle_in;
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [NODE_W-1:0]       qhead_reg [MAX_STAGES];
    logic [NODE_W-1:0]       qtail_reg [MAX_STAGES];
    logic [CNT_W-1:0]        qlen_reg  [MAX_STAGES];
    // lookahead: handle of the head node and link of the head node
    logic [HANDLE_WIDTH-1:0] qhdl_reg  [MAX_STAGES];
    logic [NODE_W-1:0]       qlnk_reg  [MAX_STAGES];

    logic [NODE_W-1:0]       free_head_reg, free_head_next;
    logic [NODE_W-1:0]       free_tail_reg, free_tail_next;
    logic [NODE_W-1:0]       free_lnk_reg,  free_lnk_next;
    logic [CNT_W-1:0]        free_len_reg,  free_len_next;
    logic [CNT_W-1:0]        fresh_reg,     fresh_next;

    // node memories and their registered read port
    logic [NODE_W-1:0]       link_mem   [POOL_DEPTH];
    logic [HANDLE_WIDTH-1:0] handle_mem [POOL_DEPTH];
    logic [NODE_W-1:0]       rd_lnk_reg;
    logic [HANDLE_WIDTH-1:0] rd_hdl_reg;

    // a read issued last cycle that must land in the lookahead registers
    logic                    qpend_reg, qpend_next;
    logic [SIDX_W-1:0]       pstage_reg;
    logic                    fpend_reg, fpend_next;

    // ------------------------------------------------------------------
    // execute
    // ------------------------------------------------------------------
    logic [SIDX_W-1:0]         sidx;
    logic                      stage_ok;
    logic [CNT_W-1:0]          len_s;
    logic [HANDLE_WIDTH-1:0]   qhdl_s;
    logic [NODE_W-1:0]         qlnk_s;
    logic [NODE_W-1:0]         free_lnk_eff;
    logic                      free_avail;
    logic                      fresh_avail;
    logic                      push_ok;
    logic                      pop_ok;
    logic [NODE_W-1:0]         new_node;
    logic [NODE_W-1:0]         pop_node;
    logic [NODE_W-1:0]         rd_addr;
    logic                      lm_we;
    logic [NODE_W-1:0]         lm_waddr;
    logic [NODE_W-1:0]         lm_wdata;

    status_t                   st_next;
    logic [HANDLE_WIDTH-1:0]   hout_next;
    logic [CNT_W-1:0]          cnt_next;
    logic                      ne_next;
    logic                      em_next;

    assign sidx     = SIDX_W'(in_stage_reg);
    assign stage_ok = (CFG_W'(in_stage_reg) < stages_in_use_reg)
                      && (32'(in_stage_reg) < 32'(MAX_STAGES));

    assign len_s    = qlen_reg[sidx];
    assign pop_node = qhead_reg[sidx];

    // take the freshly read head entry when the last pop hit this stage
    always_comb begin
        qhdl_s = qhdl_reg[sidx];
        qlnk_s = qlnk_reg[sidx];
        if (qpend_reg && pstage_reg == sidx) begin
            qhdl_s = rd_hdl_reg;
            qlnk_s = rd_lnk_reg;
        end
    end

    assign free_lnk_eff = fpend_reg ? rd_lnk_reg : free_lnk_reg;
    assign free_avail   = free_len_reg != '0;
    assign fresh_avail  = fresh_reg != CNT_W'(POOL_DEPTH);
    assign new_node     = free_avail ? free_head_reg : fresh_reg[NODE_W-1:0];

    assign push_ok = stage_ok && in_cmd_reg == CMD_PUSH && in_hdl_reg != '0
                     && (free_avail || fresh_avail);
    assign pop_ok  = stage_ok && in_cmd_reg == CMD_POP && len_s != '0;

    // result fields
    always_comb begin
        st_next   = ST_OK;
        hout_next = '0;
        cnt_next  = len_s;
        ne_next   = 1'b0;
        em_next   = 1'b0;
        if (!stage_ok) begin
            st_next  = ST_BAD_STAGE;
            cnt_next = '0;
        end else begin
            unique case (in_cmd_reg)
                CMD_PUSH: begin
                    if (in_hdl_reg == '0) begin
                        st_next  = ST_NULL_HANDLE;
                        cnt_next = '0;
                    end else if (!(free_avail || fresh_avail)) begin
                        st_next = ST_NO_NODE;
                    end else begin
                        cnt_next = len_s + CNT_W'(1);
                        ne_next  = len_s == '0;
                    end
                end
                CMD_POP: begin
                    if (len_s != '0) begin
                        hout_next = qhdl_s;
                        cnt_next  = len_s - CNT_W'(1);
                        em_next   = len_s == CNT_W'(1);
                    end
                end
                default: begin
                    // count query; command three reads the same way
                end
            endcase
        end
    end

    // memory ports: one write and one read address per cycle
    always_comb begin
        lm_we    = 1'b0;
        lm_waddr = qtail_reg[sidx];
        lm_wdata = new_node;
        rd_addr  = free_lnk_eff;
        if (push_ok) begin
            lm_we = len_s != '0;
        end else if (pop_ok) begin
            lm_we    = free_avail;
            lm_waddr = free_tail_reg;
            lm_wdata = pop_node;
            rd_addr  = qlnk_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && push_ok) begin
            handle_mem[new_node] <= in_hdl_reg;
        end
        rd_hdl_reg <= handle_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (exec && lm_we) begin
            link_mem[lm_waddr] <= lm_wdata;
        end
        rd_lnk_reg <= link_mem[rd_addr];
    end

    // free list and fresh counter
    always_comb begin
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        free_lnk_next  = free_lnk_eff;
        free_len_next  = free_len_reg;
        fresh_next     = fresh_reg;
        qpend_next     = 1'b0;
        fpend_next     = 1'b0;
        if (exec && push_ok) begin
            if (free_avail) begin
                free_head_next = free_lnk_eff;
                free_len_next  = free_len_reg - CNT_W'(1);
                fpend_next     = 1'b1;
            end else begin
                fresh_next = fresh_reg + CNT_W'(1);
            end
        end else if (exec && pop_ok) begin
            qpend_next     = 1'b1;
            free_tail_next = pop_node;
            free_len_next  = free_len_reg + CNT_W'(1);
            if (!free_avail) begin
                free_head_next = pop_node;
            end
            // a lone free node gets its link now; the memory copy is not read back
            if (free_len_reg == CNT_W'(1)) begin
                free_lnk_next = pop_node;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            free_tail_reg <= '0;
            free_lnk_reg  <= '0;
            free_len_reg  <= '0;
            fresh_reg     <= '0;
            qpend_reg     <= 1'b0;
            fpend_reg     <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            free_lnk_reg  <= free_lnk_next;
            free_len_reg  <= free_len_next;
            fresh_reg     <= fresh_next;
            qpend_reg     <= qpend_next;
            fpend_reg     <= fpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && pop_ok) begin
            pstage_reg <= sidx;
        end
    end

    // per-stage pointers; the command's own update overrides the landing read
    always_ff @(posedge aclk) begin
        if (qpend_reg) begin
            qhdl_reg[pstage_reg] <= rd_hdl_reg;
            qlnk_reg[pstage_reg] <= rd_lnk_reg;
        end
        if (exec && push_ok) begin
            qtail_reg[sidx] <= new_node;
            if (len_s == '0) begin
                qhead_reg[sidx] <= new_node;
                qhdl_reg[sidx]  <= in_hdl_reg;
            end
            if (len_s == CNT_W'(1)) begin
                qlnk_reg[sidx] <= new_node;
            end
        end else if (exec && pop_ok) begin
            if (len_s != CNT_W'(1)) begin
                qhead_reg[sidx] <= qlnk_s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                qlen_reg[i] <= '0;
            end
        end else if (exec && push_ok) begin
            qlen_reg[sidx] <= len_s + CNT_W'(1);
        end else if (exec && pop_ok) begin
            qlen_reg[sidx] <= len_s - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    status_t                 st_reg;
    logic [HANDLE_WIDTH-1:0] hout_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ne_reg;
    logic                    em_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            st_reg   <= st_next;
            hout_reg <= hout_next;
            cnt_reg  <= cnt_next;
            ne_reg   <= ne_next;
            em_reg   <= em_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = st_reg;
    assign m_handle_out      = hout_reg;
    assign m_count_out       = cnt_reg;
    assign m_became_nonempty = ne_reg;
    assign m_became_empty    = em_reg;

endmodule
`default_nettype wire

// File: hdl/mqsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqsp_checker
// Port-level checks on the result channel of the shared pool queue block.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_pool_top_assert.svh"

module mqsp_checker
    import mqsp_pkg::*;
#(
    parameter int POOL_DEPTH   = 256,
    parameter int HANDLE_WIDTH = 32
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [STATUS_W-1:0]             m_status,
    input wire logic [HANDLE_WIDTH-1:0]         m_handle_out,
    input wire logic [$clog2(POOL_DEPTH+1)-1:0] m_count_out,
    input wire logic                            m_became_nonempty,
    input wire logic                            m_became_empty
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    // hold a stalled result beat
    `MQSP_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_handle_out) && $stable(m_count_out),
        "result beat changed while stalled")

    `MQSP_ASSERT_IMPL(a_error_clean, m_valid && m_status != ST_OK,
        m_handle_out == '0 && !m_became_nonempty && !m_became_empty,
        "failed command returned a handle or a flag")

    `MQSP_ASSERT_IMPL(a_empty_flag, m_valid && m_became_empty,
        m_count_out == '0 && !m_became_nonempty && m_status == ST_OK,
        "became_empty with a non-zero length")

    `MQSP_ASSERT_IMPL(a_nonempty_flag, m_valid && m_became_nonempty,
        m_count_out == CNT_W'(1) && m_handle_out == '0 && m_status == ST_OK,
        "became_nonempty without a length of one")

endmodule

bind multi_queue_shared_pool_top mqsp_checker #(
    .POOL_DEPTH   (POOL_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
) u_mqsp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_handle_out      (m_handle_out),
    .m_count_out       (m_count_out),
    .m_became_nonempty (m_became_nonempty),
    .m_became_empty    (m_became_empty)
);
`default_nettype wire
